// ----- design/assert_macros.svh -----
// assertion macros shared by the detector rtl
// clocked on clk, disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/evad_pkg.sv -----
// shared widths, constants and types of the energy voice activity detector
// no dependencies
`timescale 1ns / 1ps

package evad_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MAG_W      = SAMPLE_W + 1;
  localparam int unsigned SQ_W       = 2 * SAMPLE_W - 1;
  localparam int unsigned MAX_FRAME  = 4096;
  localparam int unsigned CNT_W      = $clog2(MAX_FRAME + 1);
  localparam int unsigned ENERGY_W   = SQ_W + CNT_W - 1;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned TT_W       = 2 * THR_W;
  localparam int unsigned BOUND_W    = TT_W + CNT_W;
  localparam int unsigned LIMIT_W    = 24;
  localparam int unsigned TIMER_W    = 25;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic [LIMIT_W-1:0] SLACK_RST   = LIMIT_W'(48000);
  localparam logic [LIMIT_W-1:0] SILENCE_RST = LIMIT_W'(16000);
  localparam logic [THR_W-1:0]   THR_RST     = THR_W'(500);
  localparam logic [TT_W-1:0]    TT_RST      = TT_W'(500 * 500);
  localparam logic [TIMER_W-1:0] TIMER_MAX   = '1;

  // register index, byte address bits [3:2]
  localparam logic [1:0] REG_SLACK     = 2'd0;
  localparam logic [1:0] REG_SILENCE   = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam logic MODE_SAMPLE  = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  typedef enum logic [3:0] {
    PH_WAIT    = 4'b0001,
    PH_LISTEN  = 4'b0010,
    PH_TIMEOUT = 4'b0100,
    PH_ENDED   = 4'b1000
  } phase_t;

endpackage

// ----- design/evad_stream_if.sv -----
// valid/ready channels of the detector: sample input and per-frame result
// depends on evad_pkg
`timescale 1ns / 1ps

interface evad_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic signed [evad_pkg::SAMPLE_W-1:0]  sample;
  logic                                  frame_last;

  modport source (output valid, mode, sample, frame_last, input ready);
  modport sink   (input valid, mode, sample, frame_last, output ready);
endinterface

interface evad_out_if;
  logic valid;
  logic ready;
  logic silenced;
  logic speech_started;

  modport source (output valid, silenced, speech_started, input ready);
  modport sink   (input valid, silenced, speech_started, output ready);
endinterface

// ----- design/energy_voice_activity_detector.sv -----
// energy voice activity detector: frame energy against rms threshold, session phases
// depends on evad_pkg, evad_stream_if.sv and assert_macros.svh
//
//   channel  direction  handshake        payload
//   in_ch    sink       valid / ready    mode, sample, frame_last
//   out_ch   source     valid / ready    silenced, speech_started
//   cfg_*    apb slave  psel / penable   slack_limit, silence_limit, threshold
//
// one word per cycle sustained while results are taken; a frame's last word passes through the
// input register, the squaring stage and the state update into the output register
// the state update stage is one 32x13 multiply against the frame count plus a compare
// a stalled result holds a frame-last word in the update stage; the input register fills
// behind it and in_ch.ready drops until the result is taken
// rst_n is synchronous; no clearing pass, valid flags, session state and configuration reset at once
`timescale 1ns / 1ps
`include "assert_macros.svh"

module energy_voice_activity_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  evad_in_if.sink                           in_ch,
  evad_out_if.source                        out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [evad_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [evad_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [evad_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  // configuration
  logic [evad_pkg::LIMIT_W-1:0] slack_limit_r;
  logic [evad_pkg::LIMIT_W-1:0] silence_limit_r;
  logic [evad_pkg::THR_W-1:0]   thr_level_r;
  logic [evad_pkg::TT_W-1:0]    tt_r;
  logic                         cfg_wr;
  logic [1:0]                   cfg_idx;
  logic [evad_pkg::THR_W-1:0]   cfg_thr;

  // pipeline
  logic                                 s1_valid_r;
  logic                                 s1_mode_r;
  logic [evad_pkg::SAMPLE_W-1:0]        s1_sample_r;
  logic                                 s1_last_r;
  logic [evad_pkg::MAG_W-1:0]           s1_mag;
  logic [2*evad_pkg::MAG_W-1:0]         s1_prod;
  logic                                 s2_valid_r;
  logic                                 s2_mode_r;
  logic                                 s2_last_r;
  logic [evad_pkg::SQ_W-1:0]            s2_sq_r;
  logic                                 s2_prod_res;
  logic                                 s2_go;
  logic                                 s2_open;
  logic                                 out_free;
  logic                                 in_acc;

  // session state
  evad_pkg::phase_t                 phase_r, phase_nxt;
  logic [evad_pkg::TIMER_W-1:0]     slack_r, slack_nxt;
  logic [evad_pkg::TIMER_W-1:0]     quiet_r, quiet_nxt;
  logic [evad_pkg::ENERGY_W-1:0]    energy_r, energy_nxt;
  logic [evad_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic                             take;
  logic [evad_pkg::CNT_W-1:0]       cnt_n;
  logic [evad_pkg::ENERGY_W-1:0]    e_n;
  logic [evad_pkg::BOUND_W-1:0]     bound;
  logic                             loud;
  logic                             quiet;
  logic [evad_pkg::TIMER_W:0]       slack_sum;
  logic [evad_pkg::TIMER_W:0]       quiet_sum;
  logic [evad_pkg::TIMER_W-1:0]     slack_sat;
  logic [evad_pkg::TIMER_W-1:0]     quiet_sat;
  logic [evad_pkg::TIMER_W-1:0]     quiet_val;

  // result register
  logic out_valid_r;
  logic out_silenced_r;
  logic out_started_r;
  logic out_load;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_thr    = cfg_pwdata[evad_pkg::THR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slack_limit_r   <= evad_pkg::SLACK_RST;
      silence_limit_r <= evad_pkg::SILENCE_RST;
      thr_level_r     <= evad_pkg::THR_RST;
      tt_r            <= evad_pkg::TT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        evad_pkg::REG_SLACK: begin
          slack_limit_r <= cfg_pwdata[evad_pkg::LIMIT_W-1:0];
        end
        evad_pkg::REG_SILENCE: begin
          silence_limit_r <= cfg_pwdata[evad_pkg::LIMIT_W-1:0];
        end
        evad_pkg::REG_THRESHOLD: begin
          thr_level_r <= cfg_thr;
          // keep the squared threshold so the frame compare needs one multiply
          tt_r <= {{evad_pkg::THR_W{1'b0}}, cfg_thr} * {{evad_pkg::THR_W{1'b0}}, cfg_thr};
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      evad_pkg::REG_SLACK: begin
        cfg_prdata = evad_pkg::CFG_DATA_W'(slack_limit_r);
      end
      evad_pkg::REG_SILENCE: begin
        cfg_prdata = evad_pkg::CFG_DATA_W'(silence_limit_r);
      end
      evad_pkg::REG_THRESHOLD: begin
        cfg_prdata = evad_pkg::CFG_DATA_W'(thr_level_r);
      end
      default: begin
        cfg_prdata = '0;
      end
    endcase
  end

  // ---------------- flow control ----------------
  assign s2_prod_res  = s2_valid_r && (s2_mode_r == evad_pkg::MODE_SAMPLE) && s2_last_r;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s2_go        = s2_valid_r && (!s2_prod_res || out_free);
  assign s2_open      = !s2_valid_r || s2_go;
  assign in_ch.ready  = !s1_valid_r || s2_open;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_load     = s2_go && s2_prod_res;

  // ---------------- stage 1: input register, squaring ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s2_open) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r   <= in_ch.mode;
      s1_sample_r <= in_ch.sample;
      s1_last_r   <= in_ch.frame_last;
    end
  end

  // magnitude of the two's complement sample, up to 2^15
  assign s1_mag  = s1_sample_r[evad_pkg::SAMPLE_W-1]
                 ? (evad_pkg::MAG_W'(0) - {1'b1, s1_sample_r})
                 : {1'b0, s1_sample_r};
  assign s1_prod = {{evad_pkg::MAG_W{1'b0}}, s1_mag} * {{evad_pkg::MAG_W{1'b0}}, s1_mag};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_open) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_open && s1_valid_r) begin
      s2_mode_r <= s1_mode_r;
      s2_last_r <= s1_last_r;
      s2_sq_r   <= s1_prod[evad_pkg::SQ_W-1:0];
    end
  end

  // ---------------- stage 2: accumulate and judge the frame, or restart ----------------
  assign take  = count_r < evad_pkg::CNT_W'(evad_pkg::MAX_FRAME);
  assign cnt_n = take ? count_r + evad_pkg::CNT_W'(1) : count_r;
  assign e_n   = take ? energy_r + evad_pkg::ENERGY_W'(s2_sq_r) : energy_r;
  assign bound = {{evad_pkg::CNT_W{1'b0}}, tt_r} * {{evad_pkg::TT_W{1'b0}}, cnt_n};
  assign loud  = evad_pkg::BOUND_W'(e_n) > bound;
  assign quiet = evad_pkg::BOUND_W'(e_n) < bound;

  assign slack_sum = {1'b0, slack_r} + (evad_pkg::TIMER_W + 1)'(cnt_n);
  assign quiet_sum = {1'b0, quiet_r} + (evad_pkg::TIMER_W + 1)'(cnt_n);
  assign slack_sat = slack_sum[evad_pkg::TIMER_W] ? evad_pkg::TIMER_MAX
                                                  : slack_sum[evad_pkg::TIMER_W-1:0];
  assign quiet_sat = quiet_sum[evad_pkg::TIMER_W] ? evad_pkg::TIMER_MAX
                                                  : quiet_sum[evad_pkg::TIMER_W-1:0];

  always_comb begin
    phase_nxt  = phase_r;
    slack_nxt  = slack_r;
    quiet_nxt  = quiet_r;
    energy_nxt = energy_r;
    count_nxt  = count_r;
    quiet_val  = quiet ? quiet_sat : '0;
    if (s2_go) begin
      if (s2_mode_r == evad_pkg::MODE_RESTART) begin
        phase_nxt  = evad_pkg::PH_WAIT;
        slack_nxt  = '0;
        quiet_nxt  = '0;
        energy_nxt = '0;
        count_nxt  = '0;
      end else if (!s2_last_r) begin
        energy_nxt = e_n;
        count_nxt  = cnt_n;
      end else begin
        energy_nxt = '0;
        count_nxt  = '0;
        if (phase_r == evad_pkg::PH_WAIT) begin
          if (loud) begin
            phase_nxt = evad_pkg::PH_LISTEN;
          end else begin
            slack_nxt = slack_sat;
            if (slack_sat > {1'b0, slack_limit_r}) begin
              phase_nxt = evad_pkg::PH_TIMEOUT;
            end
          end
        end
        // a loud frame that ends waiting is judged again as a listening frame
        if (phase_nxt == evad_pkg::PH_LISTEN) begin
          quiet_nxt = quiet_val;
          if (quiet_val > {1'b0, silence_limit_r}) begin
            phase_nxt = evad_pkg::PH_ENDED;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= evad_pkg::PH_WAIT;
      slack_r  <= '0;
      quiet_r  <= '0;
      energy_r <= '0;
      count_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      slack_r  <= slack_nxt;
      quiet_r  <= quiet_nxt;
      energy_r <= energy_nxt;
      count_r  <= count_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_silenced_r <= (phase_nxt == evad_pkg::PH_TIMEOUT) || (phase_nxt == evad_pkg::PH_ENDED);
      out_started_r  <= (phase_nxt == evad_pkg::PH_LISTEN) || (phase_nxt == evad_pkg::PH_ENDED);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.silenced       = out_silenced_r;
  assign out_ch.speech_started = out_started_r;

  // ---------------- assertions ----------------
  `ASSERT_ALWAYS(a_count_bounded, count_r <= evad_pkg::CNT_W'(evad_pkg::MAX_FRAME),
    "frame count above the frame limit")

  `ASSERT_IMPLIES(a_stall_only_on_full, s2_valid_r && !s2_go,
    out_valid_r && !out_ch.ready, "update stage held without a blocked result")

  `ASSERT_NEXT(a_frame_cleared, s2_go && s2_last_r,
    count_r == '0 && energy_r == '0, "frame accumulators not cleared at frame end")

  `ASSERT_NEXT(a_result_matches_phase, out_load,
    out_silenced_r == ((phase_r == evad_pkg::PH_TIMEOUT) || (phase_r == evad_pkg::PH_ENDED)),
    "silenced flag disagrees with the session phase")

  `ASSERT_NEXT(a_started_sticky,
    ((phase_r == evad_pkg::PH_LISTEN) || (phase_r == evad_pkg::PH_ENDED))
      && !(s2_go && s2_mode_r == evad_pkg::MODE_RESTART),
    (phase_r == evad_pkg::PH_LISTEN) || (phase_r == evad_pkg::PH_ENDED),
    "speech started dropped without a restart")

endmodule
